// ===== design/cgoc_pkg.sv =====
// Shared types and constants of the centroid gate object counter.
// Holds payload structs, command and register codes, fixed field widths.
// No dependencies.
package cgoc_pkg;

    localparam int BOX_W     = 12;
    localparam int CMD_W     = 2;
    localparam int CLS_W     = 3;
    localparam int CNT_W     = 32;
    localparam int GATE_W    = 12;
    localparam int MASK_W    = 7;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    // (gate + 1)^2 with a 12-bit gate stays at or below 2^24
    localparam int LIM_W     = 25;
    // box coordinate plus half size, wide enough to compare with a 16-bit maximum
    localparam int WIDE_W    = 17;
    localparam int CLSN_W    = 5;

    localparam logic [CMD_W-1:0] CMD_FRAME  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DETECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_GATE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 1'd1;

    localparam logic [GATE_W-1:0] GATE_RESET = 12'd100;
    localparam logic [MASK_W-1:0] MASK_RESET = 7'd0;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [BOX_W-1:0] box_x;
        logic [BOX_W-1:0] box_y;
        logic [BOX_W-1:0] box_w;
        logic [BOX_W-1:0] box_h;
        logic [CLS_W-1:0] class_id;
    } in_item_t;

    typedef struct packed {
        logic             is_new;
        logic [BOX_W-1:0] center_x;
        logic [BOX_W-1:0] center_y;
        logic [CNT_W-1:0] total_count;
        logic [CNT_W-1:0] class_count;
        logic             overflow;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } dist_ctrl_t;

    typedef struct packed {
        logic busy;
        logic match;
    } dist_stat_t;

endpackage

// ===== design/cgoc_dist_pipe.sv =====
// Distance gate pipeline: difference, square, sum and compare per stored centroid.
// Accumulates a match flag over one scan. Depends on cgoc_pkg.
module cgoc_dist_pipe
    import cgoc_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dist_ctrl_t            ctrl,
    input  logic [COORD_BITS-1:0] slot_x,
    input  logic [COORD_BITS-1:0] slot_y,
    input  logic [COORD_BITS-1:0] cx,
    input  logic [COORD_BITS-1:0] cy,
    input  logic [LIM_W-1:0]      limit,
    output dist_stat_t            stat
);

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int SUM_W = SQ_W + 1;
    localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

    logic                  v2_reg;
    logic                  v3_reg;
    logic                  match_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;

    logic [COORD_BITS-1:0] dx_next;
    logic [COORD_BITS-1:0] dy_next;
    logic [SUM_W-1:0]      dist_sum;
    logic                  hit;

    always_comb begin
        dx_next  = (slot_x > cx) ? (slot_x - cx) : (cx - slot_x);
        dy_next  = (slot_y > cy) ? (slot_y - cy) : (cy - slot_y);
        dist_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
        hit      = CMP_W'(dist_sum) < CMP_W'(limit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            match_reg <= 1'b0;
        end else begin
            v2_reg <= ctrl.sample;
            v3_reg <= v2_reg;
            if (ctrl.clear) begin
                match_reg <= 1'b0;
            end else if (v3_reg && hit) begin
                match_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
    end

    assign stat.busy  = ctrl.sample | v2_reg | v3_reg;
    assign stat.match = match_reg;

endmodule

// ===== design/centroid_gate_object_counter.sv =====
// Top level of the centroid gate object counter: slot and class counter memories,
// command sequencer, configuration registers, output register.
// Depends on cgoc_pkg and cgoc_dist_pipe.
//
//   channel   ports                 handshake          payload
//   input     s_valid/s_ready       valid and ready    s_data  (in_item_t)
//   result    m_valid/m_ready       valid and ready    m_data  (out_item_t)
//   config    cfg_wr_en             write enable only  cfg_addr, cfg_wdata
//
// A detection runs in order: one slot memory read per cycle, then the distance pipeline
// drains, then one update step and one load step into the output register. The next
// transfer is taken in the cycle after the load.
// Frame start, clear total and unused commands give no result and leave the block ready.
// Reset clears the slot and class valid bits at once, so no clearing pass is needed.
// A stalled result holds in the output register; the block takes the next transfer
// meanwhile and waits only when a new result is ready to load.
module centroid_gate_object_counter
    import cgoc_pkg::*;
#(
    parameter int SLOTS       = 10,
    parameter int COORD_BITS  = 12,
    parameter int NUM_CLASSES = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int DEPTH   = 2 * SLOTS;
    localparam int SLOT_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCAN_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W  = $clog2(SLOTS + 1);
    localparam int CLS_IW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int ENTRY_W = 2 * COORD_BITS;

    localparam logic [WIDE_W-1:0]  COORD_MAX   = WIDE_W'((1 << COORD_BITS) - 1);
    localparam logic [SLOT_AW-1:0] SLOT_BASE   = SLOT_AW'(SLOTS);
    localparam logic [SCAN_W-1:0]  SCAN_LAST   = SCAN_W'(SLOTS - 1);
    localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(SLOTS);
    localparam logic [CLSN_W-1:0]  CLASS_LIMIT = CLSN_W'(NUM_CLASSES);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_FIN   = 3'd3;
    localparam logic [2:0] ST_PUSH  = 3'd4;

    logic [ENTRY_W-1:0]    slot_mem [DEPTH];
    logic [CNT_W-1:0]      cls_mem  [NUM_CLASSES];

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [GATE_W-1:0]     gate_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [LIM_W-1:0]      limit_reg;
    logic                  cur_buf_reg;
    logic [FILL_W-1:0]     fill_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [SCAN_W-1:0]     cnt_reg;
    logic                  v1_reg;
    logic [DEPTH-1:0]      slot_valid_reg;
    logic [NUM_CLASSES-1:0] cls_valid_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [CLS_W-1:0]      cls_reg;
    logic [ENTRY_W-1:0]    slot_q_reg;
    logic                  slot_qv_reg;
    logic [CNT_W-1:0]      cls_q_reg;
    logic                  cls_qv_reg;
    out_item_t             res_reg;
    out_item_t             m_data_reg;
    logic                  m_valid_reg;

    logic                  accept;
    logic                  push;
    logic [WIDE_W-1:0]     sum_x;
    logic [WIDE_W-1:0]     sum_y;
    logic [COORD_BITS-1:0] cx_next;
    logic [COORD_BITS-1:0] cy_next;
    logic [SLOT_AW-1:0]    raddr;
    logic [SLOT_AW-1:0]    waddr;
    logic [COORD_BITS-1:0] slot_x;
    logic [COORD_BITS-1:0] slot_y;
    logic [GATE_W:0]       gate_p1;
    logic                  in_range;
    logic [CLS_IW-1:0]     cls_idx;
    logic [MASK_W:0]       mask_ext;
    logic                  fresh;
    logic                  bump;
    logic                  room;
    logic [CNT_W-1:0]      cls_cur;
    logic [CNT_W-1:0]      cls_new;
    logic [CNT_W-1:0]      total_new;
    dist_ctrl_t            dist_ctrl;
    dist_stat_t            dist_stat;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign push    = (state_reg == ST_PUSH) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        sum_x   = WIDE_W'(s_data.box_x) + WIDE_W'(s_data.box_w >> 1);
        sum_y   = WIDE_W'(s_data.box_y) + WIDE_W'(s_data.box_h >> 1);
        cx_next = (sum_x > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(sum_x);
        cy_next = (sum_y > COORD_MAX) ? COORD_BITS'(COORD_MAX) : COORD_BITS'(sum_y);

        raddr   = (cur_buf_reg ? '0 : SLOT_BASE) + SLOT_AW'(cnt_reg);
        waddr   = (cur_buf_reg ? SLOT_BASE : '0) + SLOT_AW'(fill_reg);
        slot_x  = slot_qv_reg ? slot_q_reg[ENTRY_W-1:COORD_BITS] : '0;
        slot_y  = slot_qv_reg ? slot_q_reg[COORD_BITS-1:0] : '0;
        gate_p1 = {1'b0, gate_reg} + 1'b1;

        in_range  = {{(CLSN_W - CLS_W){1'b0}}, cls_reg} < CLASS_LIMIT;
        cls_idx   = in_range ? CLS_IW'(cls_reg) : '0;
        mask_ext  = {1'b0, mask_reg};
        fresh     = !dist_stat.match;
        bump      = fresh && in_range && mask_ext[cls_reg];
        room      = fill_reg < FILL_FULL;
        cls_cur   = cls_qv_reg ? cls_q_reg : '0;
        cls_new   = cls_cur + CNT_W'(bump);
        total_new = total_reg + CNT_W'(fresh);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.cmd == CMD_DETECT) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == SCAN_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dist_stat.busy) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (push) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign dist_ctrl.clear  = accept;
    assign dist_ctrl.sample = v1_reg;

    cgoc_dist_pipe #(
        .COORD_BITS(COORD_BITS)
    ) u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dist_ctrl),
        .slot_x  (slot_x),
        .slot_y  (slot_y),
        .cx      (cx_reg),
        .cy      (cy_reg),
        .limit   (limit_reg),
        .stat    (dist_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gate_reg       <= GATE_RESET;
            mask_reg       <= MASK_RESET;
            cur_buf_reg    <= 1'b0;
            fill_reg       <= '0;
            total_reg      <= '0;
            cnt_reg        <= '0;
            v1_reg         <= 1'b0;
            slot_valid_reg <= '0;
            cls_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= (state_reg == ST_SCAN);

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_GATE: gate_reg <= cfg_wdata[GATE_W-1:0];
                    REG_MASK: mask_reg <= cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                cnt_reg <= '0;
                unique case (s_data.cmd)
                    CMD_FRAME: begin
                        cur_buf_reg <= ~cur_buf_reg;
                        fill_reg    <= '0;
                        for (int i = 0; i < DEPTH; i++) begin
                            if ((i >= SLOTS) == !cur_buf_reg) begin
                                slot_valid_reg[i] <= 1'b0;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        total_reg <= '0;
                    end
                    default: ;
                endcase
            end else if (state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (state_reg == ST_FIN) begin
                total_reg <= total_new;
                if (room) begin
                    fill_reg              <= fill_reg + 1'b1;
                    slot_valid_reg[waddr] <= 1'b1;
                end
                if (bump) begin
                    cls_valid_reg[cls_idx] <= 1'b1;
                end
            end

            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= LIM_W'(gate_p1 * gate_p1);
        if (accept) begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            cls_reg <= s_data.class_id;
        end
        if (state_reg == ST_FIN && room) begin
            slot_mem[waddr] <= {cx_reg, cy_reg};
        end
        if (state_reg == ST_FIN && bump) begin
            cls_mem[cls_idx] <= cls_new;
        end
        slot_q_reg  <= slot_mem[raddr];
        slot_qv_reg <= slot_valid_reg[raddr];
        cls_q_reg   <= cls_mem[cls_idx];
        cls_qv_reg  <= cls_valid_reg[cls_idx];
        if (state_reg == ST_FIN) begin
            res_reg.is_new      <= fresh;
            res_reg.center_x    <= BOX_W'(cx_reg);
            res_reg.center_y    <= BOX_W'(cy_reg);
            res_reg.total_count <= total_new;
            res_reg.class_count <= in_range ? cls_new : '0;
            res_reg.overflow    <= !room;
        end
        if (push) begin
            m_data_reg <= res_reg;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("slot fill beyond capacity");

    a_fin_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !dist_stat.busy)
        else $error("update before distance pipeline drained");

    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && m_valid_reg && !m_ready) |=> (state_reg == ST_PUSH))
        else $error("pending result overwritten");

    a_frame_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.cmd == CMD_FRAME) |=> (fill_reg == '0))
        else $error("frame start did not reset slot fill");

endmodule

// ===== tb/sv/cgoc_object_count_checker.sv =====
// Scoreboard for the centroid gate object counter: watches the input, result and
// register write ports, predicts centroids and counts, and compares every result.
// Depends on cgoc_pkg.
module cgoc_object_count_checker
    import cgoc_pkg::*;
#(
    parameter int SLOTS       = 10,
    parameter int NUM_CLASSES = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_item_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int unsigned          awaiting,
    output int unsigned          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [BOX_W-1:0] COORD_MAX = '1;

    logic [2*BOX_W-1:0] centroid_mem [2*SLOTS];
    logic               write_bank;
    int unsigned        stored;
    logic [CNT_W-1:0]   new_objects;
    logic [CNT_W-1:0]   per_class [NUM_CLASSES];
    logic [GATE_W-1:0]  gate;
    logic [MASK_W-1:0]  class_mask;
    out_item_t          expected_counts [$];

    function automatic logic [BOX_W-1:0] centroid(logic [BOX_W-1:0] pos, logic [BOX_W-1:0] len);
        logic [BOX_W:0] sum;
        sum = {1'b0, pos} + {2'b0, len[BOX_W-1:1]};
        return (sum > {1'b0, COORD_MAX}) ? COORD_MAX : sum[BOX_W-1:0];
    endfunction

    function automatic logic [LIM_W-1:0] squared_gap(logic [BOX_W-1:0] a, logic [BOX_W-1:0] b);
        logic [BOX_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return LIM_W'(d) * LIM_W'(d);
    endfunction

    task automatic predict_counts(input in_item_t item);
        out_item_t        r;
        logic [LIM_W-1:0] limit;
        logic [LIM_W-1:0] dist2;
        int unsigned      rd;
        int unsigned      wr;
        case (item.cmd)
            CMD_FRAME: begin
                write_bank = ~write_bank;
                wr = write_bank ? SLOTS : 0;
                for (int i = 0; i < SLOTS; i++) centroid_mem[wr + i] = '0;
                stored = 0;
            end
            CMD_CLEAR: begin
                new_objects = '0;
            end
            CMD_DETECT: begin
                r = '0;
                r.center_x = centroid(item.box_x, item.box_w);
                r.center_y = centroid(item.box_y, item.box_h);
                wr = write_bank ? SLOTS : 0;
                rd = write_bank ? 0 : SLOTS;
                limit = (LIM_W'(gate) + 1'b1) * (LIM_W'(gate) + 1'b1);
                r.is_new = 1'b1;
                for (int i = 0; i < SLOTS; i++) begin
                    dist2 = squared_gap(r.center_x, centroid_mem[rd + i][2*BOX_W-1:BOX_W])
                          + squared_gap(r.center_y, centroid_mem[rd + i][BOX_W-1:0]);
                    if (dist2 < limit) r.is_new = 1'b0;
                end
                if (r.is_new) begin
                    new_objects++;
                    if (item.class_id < NUM_CLASSES && class_mask[item.class_id])
                        per_class[item.class_id]++;
                end
                r.total_count = new_objects;
                r.class_count = (item.class_id < NUM_CLASSES) ? per_class[item.class_id] : '0;
                if (stored < SLOTS) begin
                    centroid_mem[wr + stored] = {r.center_x, r.center_y};
                    stored++;
                end else begin
                    r.overflow = 1'b1;
                end
                expected_counts.insert(expected_counts.size(), r);
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (expected_counts.size() == 0) begin
            $error("result transfer with nothing expected: center (%0d, %0d)",
                   got.center_x, got.center_y);
            mismatches++;
        end else begin
            want = expected_counts.pop_front();
            check_field("is_new", want.is_new, got.is_new);
            check_field("center_x", want.center_x, got.center_x);
            check_field("center_y", want.center_y, got.center_y);
            check_field("total_count", want.total_count, got.total_count);
            check_field("class_count", want.class_count, got.class_count);
            check_field("overflow", want.overflow, got.overflow);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2*SLOTS; i++) centroid_mem[i] = '0;
            for (int i = 0; i < NUM_CLASSES; i++) per_class[i] = '0;
            write_bank  = 1'b0;
            stored      = 0;
            new_objects = '0;
            gate        = GATE_RESET;
            class_mask  = MASK_RESET;
            expected_counts.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_GATE: gate = cfg_wdata[GATE_W-1:0];
                    REG_MASK: class_mask = cfg_wdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) check_result(m_data);
            if (s_valid && s_ready) predict_counts(s_data);
        end
        awaiting <= expected_counts.size();
    end

endmodule

// ===== tb/sv/centroid_gate_object_counter_tb.sv =====
// Top of the centroid gate object counter testbench: clock, reset, register setup,
// frame and detection traffic, result back-pressure and the final verdict.
// Depends on cgoc_pkg, centroid_gate_object_counter and cgoc_object_count_checker.
module centroid_gate_object_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cgoc_pkg::*;

    localparam int SLOTS         = 10;
    localparam int NUM_CLASSES   = 7;
    localparam int COORD_MAX     = (1 << BOX_W) - 1;
    localparam int SETTLE_CYCLES = 24;
    localparam int DETECT_ITEMS  = 1450;
    localparam int PHASE_ITEMS   = 120;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr  = REG_GATE;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    int unsigned        awaiting;
    int unsigned        mismatches;
    int unsigned        results_taken = 0;
    int unsigned        items_sent    = 0;
    bit                 gaps_on       = 1'b1;
    int unsigned        near_spread   = 106;
    logic [2*BOX_W-1:0] last_frame [$];
    logic [2*BOX_W-1:0] this_frame [$];

    always #5 aclk = ~aclk;

    centroid_gate_object_counter #(
        .SLOTS       (SLOTS),
        .COORD_BITS  (BOX_W),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    cgoc_object_count_checker #(
        .SLOTS       (SLOTS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .awaiting   (awaiting),
        .mismatches (mismatches)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) results_taken <= results_taken + 1;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!gaps_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int on_screen(int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    function automatic int jitter();
        return int'($urandom_range(0, 2 * near_spread)) - int'(near_spread);
    endfunction

    function automatic in_item_t detection(int x, int y, int w, int h, int cls);
        in_item_t item;
        item.cmd      = CMD_DETECT;
        item.box_x    = BOX_W'(x);
        item.box_y    = BOX_W'(y);
        item.box_w    = BOX_W'(w);
        item.box_h    = BOX_W'(h);
        item.class_id = CLS_W'(cls);
        return item;
    endfunction

    function automatic in_item_t control(logic [CMD_W-1:0] cmd);
        in_item_t item;
        item = detection($urandom, $urandom, $urandom, $urandom, $urandom);
        item.cmd = cmd;
        return item;
    endfunction

    task automatic send(input in_item_t item);
        int unsigned gap;
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (item.cmd != CMD_UNUSED) items_sent++;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_detection(input int x, input int y, input int w, input int h,
                                  input int cls);
        int cx;
        int cy;
        cx = on_screen(x + w / 2);
        cy = on_screen(y + h / 2);
        this_frame.insert(this_frame.size(), {BOX_W'(cx), BOX_W'(cy)});
        send(detection(x, y, w, h, cls));
    endtask

    // hold the input low until every result has been taken, then let the block go idle
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [GATE_W-1:0] gate, input logic [MASK_W-1:0] mask);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_GATE;
        cfg_wdata <= CFG_W'(gate);
        @(posedge aclk);
        cfg_addr  <= REG_MASK;
        cfg_wdata <= {5'($urandom_range(0, 31)), mask};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        near_spread = int'(gate) + 6;
    endtask

    task automatic run_frame(input int unsigned count);
        logic [2*BOX_W-1:0] prior;
        int                 x;
        int                 y;
        int                 w;
        int                 h;
        send(control(CMD_FRAME));
        last_frame = this_frame;
        this_frame.delete();
        for (int k = 0; k < count; k++) begin
            if (last_frame.size() != 0 && $urandom_range(0, 2) != 0) begin
                prior = last_frame[$urandom_range(0, last_frame.size() - 1)];
                w = $urandom_range(0, 80);
                h = $urandom_range(0, 80);
                x = int'(prior[2*BOX_W-1:BOX_W]) - w / 2 + jitter();
                y = int'(prior[BOX_W-1:0]) - h / 2 + jitter();
            end else if ($urandom_range(0, 3) == 0) begin
                w = $urandom_range(0, COORD_MAX);
                h = $urandom_range(0, COORD_MAX);
                x = $urandom_range(0, COORD_MAX);
                y = $urandom_range(0, COORD_MAX);
            end else begin
                w = $urandom_range(0, 120);
                h = $urandom_range(0, 120);
                x = $urandom_range(0, COORD_MAX);
                y = $urandom_range(0, COORD_MAX);
            end
            send_detection(on_screen(x), on_screen(y), w, h, $urandom_range(0, 7));
        end
    endtask

    initial begin : result_sink
        int unsigned span;
        int unsigned mode;
        bit          held_off;
        held_off = 1'b0;
        forever begin
            if (!held_off && results_taken >= 150) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 9);
            span = (mode == 9) ? $urandom_range(20, 60) :
                   (mode == 8) ? $urandom_range(1, 4) : $urandom_range(1, 30);
            repeat (span) begin
                if (mode <= 3) m_ready <= 1'b1;
                else if (mode <= 7) m_ready <= ($urandom_range(0, 1) == 1);
                else m_ready <= 1'b0;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int unsigned       phase;
        int unsigned       phase_end;
        int unsigned       roll;
        int unsigned       count;
        logic [GATE_W-1:0] gate;
        logic [MASK_W-1:0] mask;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty slots at the origin, no class counted
        send(detection(0, 0, 0, 0, 0));
        send(detection(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 6));
        send(detection(2000, 1000, 100, 200, 7));
        settle();
        configure(GATE_W'(100), '1);
        send(control(CMD_UNUSED));
        send(control(CMD_FRAME));
        send(detection(4090, 4090, 0, 0, 6));
        send(detection(2050, 1100, 0, 0, 1));
        send(detection(3000, 10, 2, 2, 2));
        for (int k = 0; k < 8; k++) send(detection(400 * k, 3000, 64, 0, k));
        send(control(CMD_CLEAR));
        send(detection(100, 100, 0, 0, 3));
        send(control(CMD_FRAME));
        send(control(CMD_FRAME));
        // gate boundary against cleared slots
        send(detection(100, 0, 0, 0, 4));
        send(detection(101, 0, 0, 0, 5));
        send(detection(61, 80, 0, 0, 0));

        phase = 0;
        while (items_sent < DETECT_ITEMS) begin
            settle();
            case (phase)
                0: begin
                    gate = '0;
                    mask = '0;
                end
                1: begin
                    gate = '1;
                    mask = '1;
                end
                default: begin
                    gate = ($urandom_range(0, 3) == 0) ? GATE_W'($urandom_range(0, COORD_MAX)) :
                                                         GATE_W'($urandom_range(1, 200));
                    mask = MASK_W'($urandom_range(0, 127));
                end
            endcase
            configure(gate, mask);
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < DETECT_ITEMS) begin
                roll = $urandom_range(0, 99);
                if (roll < 6) begin
                    send(control(CMD_CLEAR));
                end else if (roll < 10) begin
                    send(control(CMD_UNUSED));
                end else if (roll < 14) begin
                    send(control(CMD_W'($urandom_range(0, 3))));
                end else begin
                    roll = $urandom_range(0, 99);
                    count = (roll < 5) ? 0 : (roll < 85) ? $urandom_range(1, SLOTS) :
                                                           $urandom_range(SLOTS + 1, SLOTS + 4);
                    run_frame(count);
                end
            end
            phase++;
        end
        settle();

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
